// ===== rtl/core/hlcfr_pkg.sv =====
// Shared types and constants for the header/length/checksum frame receiver.
package hlcfr_pkg;

  localparam int ByteWidth = 8;
  localparam int PosWidth = 9;
  localparam int ClassWidth = 3;

  localparam logic [ByteWidth-1:0] StartMark = 8'hFF;
  localparam logic [PosWidth-1:0] HeaderBytes = 9'd4;

  localparam logic [PosWidth-1:0] PosStart1 = 9'd0;
  localparam logic [PosWidth-1:0] PosStart2 = 9'd1;
  localparam logic [PosWidth-1:0] PosId = 9'd2;
  localparam logic [PosWidth-1:0] PosLen = 9'd3;

  typedef enum logic [ClassWidth-1:0] {
    CL_JUNK  = 3'd0,
    CL_START = 3'd1,
    CL_ID    = 3'd2,
    CL_LEN   = 3'd3,
    CL_PARAM = 3'd4,
    CL_CHECK = 3'd5
  } byte_class_t;

  typedef enum logic [4:0] {
    PH_HUNT1 = 5'b00001,
    PH_HUNT2 = 5'b00010,
    PH_ID    = 5'b00100,
    PH_LEN   = 5'b01000,
    PH_BODY  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    byte_class_t          byte_class;
    logic [PosWidth-1:0]  position;
    logic                 frame_end;
    logic                 frame_ok;
    logic [PosWidth-1:0]  frame_length;
  } result_t;

endpackage

// ===== rtl/core/hlcfr_parser.sv =====
// Frame parser: phase machine, running checksum and per-byte tagging.
module hlcfr_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [hlcfr_pkg::ByteWidth-1:0] rx_byte,
  output hlcfr_pkg::result_t          result
);
  import hlcfr_pkg::*;

  phase_t               phase, phase_next;
  logic [ByteWidth-1:0] running_sum, running_sum_next;
  logic [ByteWidth-1:0] bytes_left, bytes_left_next;
  logic [PosWidth-1:0]  byte_index, byte_index_next;
  logic [ByteWidth-1:0] declared_length, declared_length_next;

  logic [ByteWidth-1:0] sum_plus;
  logic                 sum_match;

  assign sum_plus = running_sum + rx_byte;
  assign sum_match = (rx_byte == ~running_sum);

  always_comb begin
    phase_next = phase;
    running_sum_next = running_sum;
    bytes_left_next = bytes_left;
    byte_index_next = byte_index;
    declared_length_next = declared_length;
    result.data_byte = rx_byte;
    result.byte_class = CL_JUNK;
    result.position = '0;
    result.frame_end = 1'b0;
    result.frame_ok = 1'b0;
    result.frame_length = '0;
    case (phase)
      PH_HUNT2: begin
        if (rx_byte == StartMark) begin
          result.byte_class = CL_START;
          result.position = PosStart2;
          phase_next = PH_ID;
        end else begin
          phase_next = PH_HUNT1;
        end
      end
      PH_ID: begin
        result.byte_class = CL_ID;
        result.position = PosId;
        running_sum_next = rx_byte;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        result.byte_class = CL_LEN;
        result.position = PosLen;
        declared_length_next = rx_byte;
        if (rx_byte == '0) begin
          // An empty body: the length byte itself closes the frame.
          result.frame_end = 1'b1;
          result.frame_ok = sum_match;
          result.frame_length = HeaderBytes;
          phase_next = PH_HUNT1;
        end else begin
          running_sum_next = sum_plus;
          bytes_left_next = rx_byte;
          byte_index_next = HeaderBytes;
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        result.position = byte_index;
        if (bytes_left <= 8'd1) begin
          result.byte_class = CL_CHECK;
          result.frame_end = 1'b1;
          result.frame_ok = sum_match;
          result.frame_length = {1'b0, declared_length} + HeaderBytes;
          bytes_left_next = '0;
          phase_next = PH_HUNT1;
        end else begin
          result.byte_class = CL_PARAM;
          running_sum_next = sum_plus;
          bytes_left_next = bytes_left - 8'd1;
          byte_index_next = byte_index + 9'd1;
        end
      end
      default: begin
        if (rx_byte == StartMark) begin
          result.byte_class = CL_START;
          result.position = PosStart1;
          phase_next = PH_HUNT2;
        end else begin
          phase_next = PH_HUNT1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT1;
      running_sum <= '0;
      bytes_left <= '0;
      byte_index <= '0;
      declared_length <= '0;
    end else if (step) begin
      phase <= phase_next;
      running_sum <= running_sum_next;
      bytes_left <= bytes_left_next;
      byte_index <= byte_index_next;
      declared_length <= declared_length_next;
    end
  end

endmodule

// ===== rtl/core/header_length_checksum_frame_receiver.sv =====
// Top level: input register, frame parser and result register.
//
//   channel  direction  handshake             payload
//   in       in         in_valid / in_ready   rx_byte
//   out      out        out_valid / out_ready data_byte, byte_class, position,
//                                             frame_end, frame_ok, frame_length
//
// Each byte passes through the input register, then through the parser into the
// result register. One byte per cycle is sustained while the output is not stalled.
// Synchronous reset returns the parser to hunting the first start byte and
// empties both registers. A stalled output holds its result while the input
// register still takes one more transfer.
module header_length_checksum_frame_receiver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hlcfr_pkg::ByteWidth-1:0]     rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hlcfr_pkg::ByteWidth-1:0]     data_byte,
  output logic [hlcfr_pkg::ClassWidth-1:0]    byte_class,
  output logic [hlcfr_pkg::PosWidth-1:0]      position,
  output logic                                frame_end,
  output logic                                frame_ok,
  output logic [hlcfr_pkg::PosWidth-1:0]      frame_length
);
  import hlcfr_pkg::*;

  logic                 in_full;
  logic [ByteWidth-1:0] in_byte;
  logic                 advance;
  result_t              result;

  assign advance = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte <= rx_byte;
    end
  end

  hlcfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_byte <= result.data_byte;
      byte_class <= result.byte_class;
      position <= result.position;
      frame_end <= result.frame_end;
      frame_ok <= result.frame_ok;
      frame_length <= result.frame_length;
    end
  end

endmodule
